FILE: hdl/kcrd_pkg.sv
// Shared types and constants for the key chord release detector.
// No dependencies; used by every module of the block.
`default_nettype none

package kcrd_pkg;

   localparam int KEY_CODES = 256;
   localparam int KEY_W     = $clog2(KEY_CODES);
   localparam int COUNT_W   = $clog2(KEY_CODES + 1);
   localparam int LAYOUT_W  = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // codes in this band are never tracked
   localparam logic [KEY_W-1:0] OEM_LOW  = KEY_W'(8'hE9);
   localparam logic [KEY_W-1:0] OEM_HIGH = KEY_W'(8'hF5);

   localparam logic [KEY_W-1:0] KEY_LSHIFT = KEY_W'(8'hA0);
   localparam logic [KEY_W-1:0] KEY_RSHIFT = KEY_W'(8'hA1);
   localparam logic [KEY_W-1:0] KEY_LCTRL  = KEY_W'(8'hA2);
   localparam logic [KEY_W-1:0] KEY_RCTRL  = KEY_W'(8'hA3);
   localparam logic [KEY_W-1:0] KEY_LALT   = KEY_W'(8'hA4);
   localparam logic [KEY_W-1:0] KEY_RALT   = KEY_W'(8'hA5);

   localparam logic [LAYOUT_W-1:0] LAYOUT_FIRST_RST  = 32'h0409_0409;
   localparam logic [LAYOUT_W-1:0] LAYOUT_SECOND_RST = 32'h0419_0419;
   localparam logic [LAYOUT_W-1:0] LAYOUT_THIRD_RST  = 32'h0411_0411;
   localparam logic [LAYOUT_W-1:0] LAYOUT_ID_MASK    = 32'h0000_FFFF;

   localparam logic [COUNT_W-1:0] CHORD_PEAK = COUNT_W'(2);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYOUT_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYOUT_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYOUT_THIRD  = 2'd2;

   typedef enum logic [1:0] {
      MOD_NONE,
      MOD_SHIFT,
      MOD_CTRL,
      MOD_ALT
   } mod_type;

   typedef struct packed {
      logic                active;
      logic                down;
      logic [KEY_W-1:0]    code;
      mod_type             modifier;
      logic [LAYOUT_W-1:0] cur_layout;
   } entry_type;

endpackage

`default_nettype wire

FILE: hdl/kcrd_front.sv
// Front end: classifies an incoming key request into a queue entry.
// Depends on kcrd_pkg.
`default_nettype none

module kcrd_front (
   input  wire logic                          event_is_action,
   input  wire logic                          key_down,
   input  wire logic [kcrd_pkg::KEY_W-1:0]    key_code,
   input  wire logic [kcrd_pkg::LAYOUT_W-1:0] current_layout,
   output kcrd_pkg::entry_type                entry
);

   logic ignored;

   assign ignored = (key_code >= kcrd_pkg::OEM_LOW) && (key_code <= kcrd_pkg::OEM_HIGH);

   always_comb begin
      entry.active     = event_is_action && !ignored;
      entry.down       = key_down;
      entry.code       = key_code;
      entry.cur_layout = current_layout;
      unique case (key_code)
         kcrd_pkg::KEY_LSHIFT, kcrd_pkg::KEY_RSHIFT: entry.modifier = kcrd_pkg::MOD_SHIFT;
         kcrd_pkg::KEY_LCTRL,  kcrd_pkg::KEY_RCTRL:  entry.modifier = kcrd_pkg::MOD_CTRL;
         kcrd_pkg::KEY_LALT,   kcrd_pkg::KEY_RALT:   entry.modifier = kcrd_pkg::MOD_ALT;
         default:                                    entry.modifier = kcrd_pkg::MOD_NONE;
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/kcrd_queue.sv
// Short FIFO between the classifier and the execution stage.
// Depends on kcrd_pkg.
`default_nettype none

module kcrd_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire kcrd_pkg::entry_type push_entry,
   output logic               not_full,
   input  wire logic          pop,
   output logic               head_valid,
   output kcrd_pkg::entry_type head_entry
);

   kcrd_pkg::entry_type             slot_ff [kcrd_pkg::QUEUE_DEPTH];
   logic [kcrd_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [kcrd_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [kcrd_pkg::QCNT_W-1:0]     count_ff, count_in;

   localparam logic [kcrd_pkg::QPTR_W-1:0] LAST_SLOT = kcrd_pkg::QPTR_W'(kcrd_pkg::QUEUE_DEPTH - 1);
   localparam logic [kcrd_pkg::QCNT_W-1:0] FULL_CNT  = kcrd_pkg::QCNT_W'(kcrd_pkg::QUEUE_DEPTH);

   assign not_full   = (count_ff != FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + kcrd_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + kcrd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + kcrd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - kcrd_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_CNT)
      else $error("queue count above depth");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + kcrd_pkg::QCNT_W'(1))
      else $error("queue count missed a push");
   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: hdl/kcrd_back.sv
// Execution stage: held-key map, counters, chord decision, layout registers
// and the registered response. Depends on kcrd_pkg.
`default_nettype none

module kcrd_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [kcrd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [kcrd_pkg::LAYOUT_W-1:0]      csr_write_data,
   input  wire logic                               head_valid,
   input  wire kcrd_pkg::entry_type                head_entry,
   output logic                                    pop,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_switch_request,
   output logic [kcrd_pkg::LAYOUT_W-1:0]           rsp_new_layout
);

   logic [kcrd_pkg::LAYOUT_W-1:0]  layout_first_ff, layout_second_ff, layout_third_ff;
   logic [kcrd_pkg::KEY_CODES-1:0] held_map_ff, held_map_in;
   logic [kcrd_pkg::COUNT_W-1:0]   held_count_ff, held_count_in;
   logic [kcrd_pkg::COUNT_W-1:0]   peak_count_ff, peak_count_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           switch_ff, switch_in;
   logic [kcrd_pkg::LAYOUT_W-1:0]  layout_ff, layout_in;

   logic                          hit, chord, toggle, third;
   logic                          shift_held, ctrl_held, alt_held;
   logic [kcrd_pkg::KEY_W-1:0]    code;

   assign pop                = head_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_switch_request = switch_ff;
   assign rsp_new_layout     = layout_ff;

   assign code = head_entry.code;
   assign hit  = held_map_ff[code];

   // modifier state as it stands once the released key's bit is cleared
   assign shift_held = (held_map_ff[kcrd_pkg::KEY_LSHIFT] && code != kcrd_pkg::KEY_LSHIFT)
                    || (held_map_ff[kcrd_pkg::KEY_RSHIFT] && code != kcrd_pkg::KEY_RSHIFT);
   assign ctrl_held  = (held_map_ff[kcrd_pkg::KEY_LCTRL] && code != kcrd_pkg::KEY_LCTRL)
                    || (held_map_ff[kcrd_pkg::KEY_RCTRL] && code != kcrd_pkg::KEY_RCTRL);
   assign alt_held   = (held_map_ff[kcrd_pkg::KEY_LALT] && code != kcrd_pkg::KEY_LALT)
                    || (held_map_ff[kcrd_pkg::KEY_RALT] && code != kcrd_pkg::KEY_RALT);

   always_comb begin
      held_map_in   = held_map_ff;
      held_count_in = held_count_ff;
      peak_count_in = peak_count_ff;
      chord         = 1'b0;
      toggle        = 1'b0;
      third         = 1'b0;
      if (head_entry.active) begin
         if (head_entry.down) begin
            if (!hit) begin
               held_count_in = held_count_ff + kcrd_pkg::COUNT_W'(1);
            end
            if (peak_count_ff < held_count_in) begin
               peak_count_in = held_count_in;
            end
            held_map_in[code] = 1'b1;
         end else begin
            if (hit && held_count_ff != '0) begin
               held_count_in = held_count_ff - kcrd_pkg::COUNT_W'(1);
            end
            if (held_count_in == '0) begin
               peak_count_in = '0;
            end
            chord = (held_count_in == kcrd_pkg::COUNT_W'(1))
                 && (peak_count_in == kcrd_pkg::CHORD_PEAK);
            held_map_in[code] = 1'b0;
            case (head_entry.modifier)
               kcrd_pkg::MOD_CTRL:  toggle = shift_held && !alt_held;
               kcrd_pkg::MOD_ALT:   third  = shift_held && !ctrl_held;
               kcrd_pkg::MOD_SHIFT: begin
                  third  = alt_held && !ctrl_held;
                  toggle = ctrl_held && !alt_held;
               end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      switch_in = 1'b0;
      layout_in = '0;
      if (chord) begin
         if (toggle) begin
            switch_in = 1'b1;
            layout_in = (head_entry.cur_layout == layout_first_ff) ? layout_second_ff
                                                                   : layout_first_ff;
         end else if (third && ((head_entry.cur_layout & kcrd_pkg::LAYOUT_ID_MASK)
                             != (layout_third_ff & kcrd_pkg::LAYOUT_ID_MASK))) begin
            switch_in = 1'b1;
            layout_in = layout_third_ff;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_map_ff      <= '0;
         held_count_ff    <= '0;
         peak_count_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
         layout_first_ff  <= kcrd_pkg::LAYOUT_FIRST_RST;
         layout_second_ff <= kcrd_pkg::LAYOUT_SECOND_RST;
         layout_third_ff  <= kcrd_pkg::LAYOUT_THIRD_RST;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            held_map_ff   <= held_map_in;
            held_count_ff <= held_count_in;
            peak_count_ff <= peak_count_in;
         end
         if (csr_write_enable) begin
            case (csr_index)
               kcrd_pkg::CSR_LAYOUT_FIRST:  layout_first_ff  <= csr_write_data;
               kcrd_pkg::CSR_LAYOUT_SECOND: layout_second_ff <= csr_write_data;
               kcrd_pkg::CSR_LAYOUT_THIRD:  layout_third_ff  <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         switch_ff <= switch_in;
         layout_ff <= layout_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) peak_count_ff >= held_count_ff)
      else $error("peak count below held count");
   assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= kcrd_pkg::COUNT_W'(kcrd_pkg::KEY_CODES))
      else $error("held count above number of keys");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !switch_ff |-> layout_ff == '0)
      else $error("layout driven without a switch request");

endmodule

`default_nettype wire

FILE: hdl/key_chord_release_detector.sv
// Key chord release detector: top level tying classifier, queue and execution stage.
// Depends on kcrd_pkg, kcrd_front, kcrd_queue and kcrd_back.
//
// Takes one key request per cycle while req_ready is high and returns exactly
// one response per request, in order. A request is written into the two-entry
// queue when it is accepted; from the queue head it is processed into the output
// register once that register is empty or its response is being taken, so
// rsp_ready back-pressure can hold it in the queue. Sustained throughput is one
// request per clock while rsp_ready stays high, with the held-key map and
// counters in the execution stage updated for every popped request. The map lives
// in flip-flops and is cleared by reset at once, so no clearing pass is needed.
// Layout registers are written on the csr_ port and should only change while idle.
`default_nettype none

module key_chord_release_detector (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_enable,
   input  wire logic [kcrd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [kcrd_pkg::LAYOUT_W-1:0]  csr_write_data,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_event_is_action,
   input  wire logic                           req_key_down,
   input  wire logic [kcrd_pkg::KEY_W-1:0]     req_key_code,
   input  wire logic [kcrd_pkg::LAYOUT_W-1:0]  req_current_layout,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_switch_request,
   output logic [kcrd_pkg::LAYOUT_W-1:0]       rsp_new_layout
);

   kcrd_pkg::entry_type front_entry, head_entry;
   logic                q_not_full, head_valid, pop;

   assign req_ready = q_not_full;

   kcrd_front u_front (
      .event_is_action (req_event_is_action),
      .key_down        (req_key_down),
      .key_code        (req_key_code),
      .current_layout  (req_current_layout),
      .entry           (front_entry)
   );

   kcrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && q_not_full),
      .push_entry (front_entry),
      .not_full   (q_not_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   kcrd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .head_valid         (head_valid),
      .head_entry         (head_entry),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_switch_request (rsp_switch_request),
      .rsp_new_layout     (rsp_new_layout)
   );

endmodule

`default_nettype wire
